>>> hdl/keyboard_make_break_auto_repeat_top_defines.svh
// Assertion macros for the keyboard make/break and auto-repeat block.
`ifndef KEYBOARD_MAKE_BREAK_AUTO_REPEAT_TOP_DEFINES_SVH
`define KEYBOARD_MAKE_BREAK_AUTO_REPEAT_TOP_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define KMBAR_ASSERT_CLK(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("kmbar assertion failed");

// Assertion on the block clock and reset.
`define KMBAR_ASSERT(lbl, prop) \
	`KMBAR_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

>>> hdl/kmbar_pkg.sv
// Types and constants shared by the keyboard make/break and auto-repeat block.
`default_nettype none
package kmbar_pkg;

	localparam int TIME_W = 48;
	localparam int REG_W  = 24;

	localparam logic [1:0] REQ_PRESS   = 2'd0;
	localparam logic [1:0] REQ_RELEASE = 2'd1;
	localparam logic [1:0] REQ_ADVANCE = 2'd2;

	localparam logic CFG_DELAY  = 1'b0;
	localparam logic CFG_PERIOD = 1'b1;

	localparam logic [REG_W-1:0] DELAY_RST  = 24'd500;
	localparam logic [REG_W-1:0] PERIOD_RST = 24'd33;

	localparam logic [7:0] BREAK_BIT = 8'h80;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [7:0]        key_index;
		logic [TIME_W-1:0] tick_time;
	} req_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] event_code;
		logic [6:0] repeat_key;
	} rsp_t;

	typedef struct packed {
		logic [REG_W-1:0] repeat_delay;
		logic [REG_W-1:0] repeat_period;
	} cfg_t;

endpackage
`default_nettype wire

>>> hdl/kmbar_core.sv
// Key bitmap, repeat timer state and the combinational event decision.
`default_nettype none
module kmbar_core #(
	parameter int NUM_KEYS = 128
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire kmbar_pkg::req_t req,
	input  wire kmbar_pkg::cfg_t cfg,
	output kmbar_pkg::rsp_t      rsp
);
	import kmbar_pkg::*;

	localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [REG_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + (TIME_W+1)'(b);
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

	logic [NUM_KEYS-1:0] key_down_q;
	logic                held_vld_q;
	logic [KEY_W-1:0]    held_idx_q;
	logic [TIME_W-1:0]   due_q;
	logic [TIME_W-1:0]   cur_q;

	logic [KEY_W-1:0]  idx;
	logic              key_ok;
	logic              is_down;
	logic              press_ok;
	logic              release_ok;
	logic              repeat_ok;
	logic              is_adv;
	logic [TIME_W-1:0] cur_nxt;

	assign idx        = req.key_index[KEY_W-1:0];
	assign key_ok     = req.key_index < 8'(NUM_KEYS);
	assign is_down    = key_ok && key_down_q[idx];
	assign press_ok   = (req.req_type == REQ_PRESS) && key_ok && !is_down;
	assign release_ok = (req.req_type == REQ_RELEASE) && is_down;
	assign is_adv     = req.req_type == REQ_ADVANCE;
	// Time only moves forward; an older stamp leaves the clock alone.
	assign cur_nxt    = (is_adv && (req.tick_time > cur_q)) ? req.tick_time : cur_q;
	assign repeat_ok  = is_adv && held_vld_q && (cur_nxt >= due_q);

	always_comb begin
		rsp = '0;
		if (press_ok) begin
			rsp.accepted   = 1'b1;
			rsp.event_code = req.key_index;
		end else if (release_ok) begin
			rsp.accepted   = 1'b1;
			rsp.event_code = req.key_index | BREAK_BIT;
		end else if (repeat_ok) begin
			rsp.accepted   = 1'b1;
			rsp.event_code = 8'(held_idx_q);
			rsp.repeat_key = 7'(held_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_q <= '0;
			held_vld_q <= 1'b0;
			held_idx_q <= '0;
			due_q      <= '0;
			cur_q      <= '0;
		end else if (fire) begin
			cur_q <= cur_nxt;
			if (press_ok) begin
				key_down_q[idx] <= 1'b1;
				held_vld_q      <= 1'b1;
				held_idx_q      <= idx;
				due_q           <= sat_add(cur_q, cfg.repeat_delay);
			end
			if (release_ok) begin
				key_down_q[idx] <= 1'b0;
				// Releasing the repeating key stops the repeat until a key is pressed again.
				if (held_vld_q && (held_idx_q == idx)) begin
					held_vld_q <= 1'b0;
				end
			end
			if (repeat_ok) begin
				due_q <= sat_add(due_q, cfg.repeat_period);
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/keyboard_make_break_auto_repeat_top.sv
// Each transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while the output is not stalled; a stalled output backs up through one stage.
// The rate is set by the combinational bitmap test and 48-bit add and compare in the core.
// Reset clears the key bitmap, repeating key, due time and clock, and loads
// the delay and period registers with 500 and 33 ticks.
`default_nettype none
module keyboard_make_break_auto_repeat_top #(
	parameter int NUM_KEYS = 128
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire kmbar_pkg::req_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output kmbar_pkg::rsp_t      out_data,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [23:0]     cfg_data
);
	import kmbar_pkg::*;

	logic  v_s1;
	req_t  req_s1;
	logic  out_valid_q;
	rsp_t  rsp_q;
	cfg_t  cfg_q;
	rsp_t  rsp;
	logic  adv;

	assign adv       = v_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !v_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	kmbar_core #(
		.NUM_KEYS(NUM_KEYS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (adv),
		.req   (req_s1),
		.cfg   (cfg_q),
		.rsp   (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
		if (adv) begin
			rsp_q <= rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.repeat_delay  <= DELAY_RST;
			cfg_q.repeat_period <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DELAY:  cfg_q.repeat_delay  <= cfg_data;
				CFG_PERIOD: cfg_q.repeat_period <= cfg_data;
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/kmbar_checker.sv
// Port-level checks for the keyboard make/break and auto-repeat block, with bind.
`default_nettype none
`include "keyboard_make_break_auto_repeat_top_defines.svh"
module kmbar_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire kmbar_pkg::rsp_t out_data
);
	import kmbar_pkg::*;

	// A stalled result must hold until it is taken.
	`KMBAR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

	// A rejected transaction carries no code at all.
	`KMBAR_ASSERT(a_reject_zero, out_valid && !out_data.accepted |-> out_data.event_code == 8'd0 && out_data.repeat_key == 7'd0)

	// A repeat reports the same key in both fields.
	`KMBAR_ASSERT(a_repeat_match, out_valid && out_data.repeat_key != 7'd0 |-> out_data.event_code == 8'(out_data.repeat_key))

	// A break code never comes with a repeat key.
	`KMBAR_ASSERT(a_break_norep, out_valid && out_data.event_code[7] |-> out_data.repeat_key == 7'd0 && out_data.accepted)

endmodule

bind keyboard_make_break_auto_repeat_top kmbar_checker u_kmbar_checker (.*);
`default_nettype wire
